>>> sv/stnh_pkg.sv
// Shared types and constants for the segment/triangle nearest-hit block.
// Holds the micro-program of the shared multiply-accumulate unit.
// No dependencies.
`default_nettype none

package stnh_pkg;

   // Default coordinate width (two's complement, Q16.16 by default)
   localparam int COORD_WIDTH_DEF = 32;

   // Crossing fraction is unsigned Q0.32
   localparam int FRAC_Q = 32;
   localparam logic [FRAC_Q:0] FRAC_ONE = {1'b1, {FRAC_Q{1'b0}}};

   // Multiplier digit width of the shared unit
   localparam int DIGIT_BITS = 16;

   // Configuration register index
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_Z   = 3'd5
   } csr_idx_type;

   // Triangle edges walked by the inside test
   localparam int NUM_EDGES = 3;

   // Operand sources of the shared unit
   typedef enum logic [4:0] {
      SRC_E1X, SRC_E1Y, SRC_E1Z,   // B - A
      SRC_E2X, SRC_E2Y, SRC_E2Z,   // C - A
      SRC_DSX, SRC_DSY, SRC_DSZ,   // S - A
      SRC_DEX, SRC_DEY, SRC_DEZ,   // E - A
      SRC_SGX, SRC_SGY, SRC_SGZ,   // E - S
      SRC_PDX, SRC_PDY, SRC_PDZ,   // P - A
      SRC_N0,  SRC_N1,  SRC_N2,    // plane normal
      SRC_C0,  SRC_C1,  SRC_C2,    // edge cross product
      SRC_F                        // crossing fraction
   } src_type;

   // Where the accumulator goes when a step finishes
   typedef enum logic [3:0] {
      DST_NONE,
      DST_N0, DST_N1, DST_N2,
      DST_SD, DST_ED,
      DST_PX, DST_PY, DST_PZ,
      DST_C0, DST_C1, DST_C2,
      DST_K
   } dst_type;

   typedef struct packed {
      logic    clr;    // start from zero instead of the accumulator
      logic    neg;    // subtract the product
      src_type src_a;
      src_type src_b;
      dst_type dst;
   } mac_op_type;

   // Program steps
   localparam int STEP_W    = 5;
   localparam int PROG_LEN  = 24;
   localparam logic [STEP_W-1:0] STEP_ED   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_P    = 5'd12;
   localparam logic [STEP_W-1:0] STEP_EDGE = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LAST = 5'd23;

   localparam mac_op_type PROG [PROG_LEN] = '{
      // normal n = (B-A) x (C-A)
      '{1'b1, 1'b0, SRC_E1Y, SRC_E2Z, DST_NONE},
      '{1'b0, 1'b1, SRC_E1Z, SRC_E2Y, DST_N0},
      '{1'b1, 1'b0, SRC_E1Z, SRC_E2X, DST_NONE},
      '{1'b0, 1'b1, SRC_E1X, SRC_E2Z, DST_N1},
      '{1'b1, 1'b0, SRC_E1X, SRC_E2Y, DST_NONE},
      '{1'b0, 1'b1, SRC_E1Y, SRC_E2X, DST_N2},
      // plane distances of both endpoints
      '{1'b1, 1'b0, SRC_N0, SRC_DSX, DST_NONE},
      '{1'b0, 1'b0, SRC_N1, SRC_DSY, DST_NONE},
      '{1'b0, 1'b0, SRC_N2, SRC_DSZ, DST_SD},
      '{1'b1, 1'b0, SRC_N0, SRC_DEX, DST_NONE},
      '{1'b0, 1'b0, SRC_N1, SRC_DEY, DST_NONE},
      '{1'b0, 1'b0, SRC_N2, SRC_DEZ, DST_ED},
      // crossing point
      '{1'b1, 1'b0, SRC_SGX, SRC_F, DST_PX},
      '{1'b1, 1'b0, SRC_SGY, SRC_F, DST_PY},
      '{1'b1, 1'b0, SRC_SGZ, SRC_F, DST_PZ},
      // edge cross product (B-A) x (P-A), vertices rotated per edge
      '{1'b1, 1'b0, SRC_E1Y, SRC_PDZ, DST_NONE},
      '{1'b0, 1'b1, SRC_E1Z, SRC_PDY, DST_C0},
      '{1'b1, 1'b0, SRC_E1Z, SRC_PDX, DST_NONE},
      '{1'b0, 1'b1, SRC_E1X, SRC_PDZ, DST_C1},
      '{1'b1, 1'b0, SRC_E1X, SRC_PDY, DST_NONE},
      '{1'b0, 1'b1, SRC_E1Y, SRC_PDX, DST_C2},
      // edge value along the normal
      '{1'b1, 1'b0, SRC_C0, SRC_N0, DST_NONE},
      '{1'b0, 1'b0, SRC_C1, SRC_N1, DST_NONE},
      '{1'b0, 1'b0, SRC_C2, SRC_N2, DST_K}
   };

endpackage : stnh_pkg

`default_nettype wire

>>> sv/segment_triangle_nearest_hit_core.sv
// A full test runs all 42 products in turn on the one shared multiply-accumulate
// unit, plus the bit-serial divider; a triangle that misses the plane stops after
// the first 12 products. The multiplier has NDIG = ceil((2*COORD_WIDTH+3)/16) digits.
// One triangle at a time; the result word waits in its own register.
// Reset: synchronous, active high; clears segment, query state and nearest point.
`default_nettype none

module segment_triangle_nearest_hit_core
   import stnh_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z from bit 0 up
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                  req_tlast,
   // response: hit_x,hit_y,hit_z from bit 0 up
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // response: any_hit
   output logic                       rsp_tuser,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int NW  = 2 * DW + 1;
   localparam int SW  = NW + DW + 2;
   localparam int EW  = 2 * NW + 2;
   localparam int RDW = ((3 * CW + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_WAIT, ST_TEST, ST_DIV, ST_FIN
   } state_type;

   state_type state_ff, state_in;

   logic signed [CW-1:0] va_ff [3], va_in [3];
   logic signed [CW-1:0] vb_ff [3], vb_in [3];
   logic signed [CW-1:0] vc_ff [3], vc_in [3];
   logic signed [CW-1:0] ss_ff [3], ss_in [3];
   logic signed [CW-1:0] se_ff [3], se_in [3];
   logic signed [CW-1:0] p_ff [3], p_in [3];
   logic signed [CW-1:0] near_ff [3], near_in [3];
   logic signed [CW-1:0] rpt_ff [3], rpt_in [3];
   logic signed [NW-1:0] n_ff [3], n_in [3];
   logic signed [NW-1:0] c_ff [3], c_in [3];
   logic signed [SW-1:0] sd_ff, sd_in;
   logic signed [SW-1:0] ed_ff, ed_in;
   logic [FRAC_Q-1:0]    f_ff, f_in;
   logic [FRAC_Q:0]      best_ff, best_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [1:0]           edge_ff, edge_in;
   logic                 pos_ff, pos_in;
   logic                 neg_ff, neg_in;
   logic                 tri_hit_ff, tri_hit_in;
   logic                 last_ff, last_in;
   logic                 qopen_ff, qopen_in;
   logic                 qhit_ff, qhit_in;
   logic                 rvalid_ff, rvalid_in;
   logic                 rhit_ff, rhit_in;

   logic signed [DW-1:0] e1 [3], e2 [3], dsv [3], dev [3], sg [3], pd [3];

   mac_op_type           op;
   logic signed [NW-1:0] opnd_a, opnd_b;
   logic                 mac_start, mac_done;
   logic signed [EW-1:0] acc;
   logic                 div_start, div_done;
   logic [FRAC_Q-1:0]    quot;
   logic [SW-1:0]        sd_mag, ed_mag;
   logic [SW:0]          den;
   logic                 k_pos, k_neg, skip, take, rsp_free;

   localparam logic [1:0] EDGE_LAST = 2'(NUM_EDGES - 1);

   // differences feeding the shared unit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i]  = DW'(vb_ff[i]) - DW'(va_ff[i]);
         e2[i]  = DW'(vc_ff[i]) - DW'(va_ff[i]);
         dsv[i] = DW'(ss_ff[i]) - DW'(va_ff[i]);
         dev[i] = DW'(se_ff[i]) - DW'(va_ff[i]);
         sg[i]  = DW'(se_ff[i]) - DW'(ss_ff[i]);
         pd[i]  = DW'(p_ff[i])  - DW'(va_ff[i]);
      end
   end

   function automatic logic signed [NW-1:0] pick(src_type s);
      logic signed [NW-1:0] r;
      r = '0;
      unique case (s)
         SRC_E1X: r = NW'(e1[0]);
         SRC_E1Y: r = NW'(e1[1]);
         SRC_E1Z: r = NW'(e1[2]);
         SRC_E2X: r = NW'(e2[0]);
         SRC_E2Y: r = NW'(e2[1]);
         SRC_E2Z: r = NW'(e2[2]);
         SRC_DSX: r = NW'(dsv[0]);
         SRC_DSY: r = NW'(dsv[1]);
         SRC_DSZ: r = NW'(dsv[2]);
         SRC_DEX: r = NW'(dev[0]);
         SRC_DEY: r = NW'(dev[1]);
         SRC_DEZ: r = NW'(dev[2]);
         SRC_SGX: r = NW'(sg[0]);
         SRC_SGY: r = NW'(sg[1]);
         SRC_SGZ: r = NW'(sg[2]);
         SRC_PDX: r = NW'(pd[0]);
         SRC_PDY: r = NW'(pd[1]);
         SRC_PDZ: r = NW'(pd[2]);
         SRC_N0:  r = n_ff[0];
         SRC_N1:  r = n_ff[1];
         SRC_N2:  r = n_ff[2];
         SRC_C0:  r = c_ff[0];
         SRC_C1:  r = c_ff[1];
         SRC_C2:  r = c_ff[2];
         SRC_F:   r = NW'($signed({1'b0, f_ff}));
         default: r = '0;
      endcase
      return r;
   endfunction

   assign op = PROG[step_ff];

   // select both operands of the current step
   always_comb begin
      opnd_a = pick(op.src_a);
      opnd_b = pick(op.src_b);
   end

   stnh_mac #(
      .MW (NW),
      .EW (EW)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .clr    (op.clr),
      .neg    (op.neg),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .done   (mac_done),
      .acc    (acc)
   );

   // magnitudes of the plane distances
   assign sd_mag = sd_ff[SW-1] ? SW'(-sd_ff) : SW'(sd_ff);
   assign ed_mag = ed_ff[SW-1] ? SW'(-ed_ff) : SW'(ed_ff);
   assign den    = {1'b0, sd_mag} + {1'b0, ed_mag};
   assign skip   = (sd_ff == '0) || (ed_ff == '0) || (sd_ff[SW-1] == ed_ff[SW-1]);

   stnh_div #(
      .SW (SW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sd_mag),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   assign k_neg    = acc[EW-1];
   assign k_pos    = !acc[EW-1] && (acc != '0);
   assign take     = tri_hit_ff && ({1'b0, f_ff} < best_ff);
   assign rsp_free = !rvalid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      vc_in      = vc_ff;
      ss_in      = ss_ff;
      se_in      = se_ff;
      p_in       = p_ff;
      near_in    = near_ff;
      rpt_in     = rpt_ff;
      n_in       = n_ff;
      c_in       = c_ff;
      sd_in      = sd_ff;
      ed_in      = ed_ff;
      f_in       = f_ff;
      best_in    = best_ff;
      step_in    = step_ff;
      edge_in    = edge_ff;
      pos_in     = pos_ff;
      neg_in     = neg_ff;
      tri_hit_in = tri_hit_ff;
      last_in    = last_ff;
      qopen_in   = qopen_ff;
      qhit_in    = qhit_ff;
      rhit_in    = rhit_ff;
      rvalid_in  = rvalid_ff && !rsp_tready;
      mac_start  = 1'b0;
      div_start  = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_START_X: ss_in[0] = csr_wdata;
            CSR_START_Y: ss_in[1] = csr_wdata;
            CSR_START_Z: ss_in[2] = csr_wdata;
            CSR_END_X:   se_in[0] = csr_wdata;
            CSR_END_Y:   se_in[1] = csr_wdata;
            CSR_END_Z:   se_in[2] = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  va_in[i] = req_tdata[i*CW +: CW];
                  vb_in[i] = req_tdata[(i+3)*CW +: CW];
                  vc_in[i] = req_tdata[(i+6)*CW +: CW];
               end
               last_in = req_tlast;
               if (!qopen_ff) begin
                  qhit_in  = 1'b0;
                  best_in  = FRAC_ONE;
                  qopen_in = 1'b1;
               end
               step_in  = '0;
               edge_in  = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mac_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (mac_done) begin
               // store the finished sum
               unique case (op.dst)
                  DST_N0: n_in[0] = acc[NW-1:0];
                  DST_N1: n_in[1] = acc[NW-1:0];
                  DST_N2: n_in[2] = acc[NW-1:0];
                  DST_SD: sd_in   = acc[SW-1:0];
                  DST_ED: ed_in   = acc[SW-1:0];
                  DST_PX: p_in[0] = ss_ff[0] + acc[FRAC_Q+CW-1:FRAC_Q];
                  DST_PY: p_in[1] = ss_ff[1] + acc[FRAC_Q+CW-1:FRAC_Q];
                  DST_PZ: p_in[2] = ss_ff[2] + acc[FRAC_Q+CW-1:FRAC_Q];
                  DST_C0: c_in[0] = acc[NW-1:0];
                  DST_C1: c_in[1] = acc[NW-1:0];
                  DST_C2: c_in[2] = acc[NW-1:0];
                  DST_K: begin
                     pos_in = ((edge_ff == '0) || pos_ff) && k_pos;
                     neg_in = ((edge_ff == '0) || neg_ff) && k_neg;
                  end
                  default: ;
               endcase
               // advance the program
               priority if (step_ff == STEP_ED) begin
                  state_in = ST_TEST;
               end else if (step_ff == STEP_LAST) begin
                  if (edge_ff == EDGE_LAST) begin
                     tri_hit_in = (((edge_ff == '0) || pos_ff) && k_pos) ||
                                  (((edge_ff == '0) || neg_ff) && k_neg);
                     state_in   = ST_FIN;
                  end else begin
                     // rotate so the next edge starts at A
                     va_in    = vb_ff;
                     vb_in    = vc_ff;
                     vc_in    = va_ff;
                     edge_in  = edge_ff + 1'b1;
                     step_in  = STEP_EDGE;
                     state_in = ST_ISSUE;
                  end
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_TEST: begin
            if (skip) begin
               tri_hit_in = 1'b0;
               state_in   = ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               f_in     = quot;
               step_in  = STEP_P;
               state_in = ST_ISSUE;
            end
         end
         ST_FIN: begin
            // keep the nearest hit; safe to repeat while the result waits
            if (tri_hit_ff) begin
               qhit_in = 1'b1;
            end
            if (take) begin
               best_in = {1'b0, f_ff};
               near_in = p_ff;
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rvalid_in = 1'b1;
               rhit_in   = qhit_ff || tri_hit_ff;
               rpt_in    = take ? p_ff : near_ff;
               qopen_in  = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         qopen_ff  <= 1'b0;
         qhit_ff   <= 1'b0;
         best_ff   <= FRAC_ONE;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            ss_ff[i]   <= '0;
            se_ff[i]   <= '0;
            near_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         qopen_ff  <= qopen_in;
         qhit_ff   <= qhit_in;
         best_ff   <= best_in;
         rvalid_ff <= rvalid_in;
         ss_ff     <= ss_in;
         se_ff     <= se_in;
         near_ff   <= near_in;
      end
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      vc_ff      <= vc_in;
      p_ff       <= p_in;
      rpt_ff     <= rpt_in;
      n_ff       <= n_in;
      c_ff       <= c_in;
      sd_ff      <= sd_in;
      ed_ff      <= ed_in;
      f_ff       <= f_in;
      step_ff    <= step_in;
      edge_ff    <= edge_in;
      pos_ff     <= pos_in;
      neg_ff     <= neg_in;
      tri_hit_ff <= tri_hit_in;
      last_ff    <= last_in;
      rhit_ff    <= rhit_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rhit_ff;
   assign rsp_tdata  = RDW'({rpt_ff[2], rpt_ff[1], rpt_ff[0]});

`ifndef SYNTHESIS
   a_best_bounded: assert property (@(posedge clock) disable iff (reset)
      best_ff <= FRAC_ONE)
      else $error("best fraction above one");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide phase");

   a_query_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && last_ff && rsp_free) |=> !qopen_ff && rvalid_ff)
      else $error("query not closed after result");

   a_hit_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && tri_hit_ff && !last_ff) |=> qhit_ff)
      else $error("hit not recorded");
`endif

endmodule : segment_triangle_nearest_hit_core

`default_nettype wire

>>> sv/stnh_mac.sv
// Shared multiply-accumulate unit: acc = (clr ? 0 : acc) +/- a * b.
// Multiplier is taken one signed-aware digit per cycle, top digit first.
// Depends on stnh_pkg.
`default_nettype none

module stnh_mac
   import stnh_pkg::*;
#(
   parameter int MW = 2 * (COORD_WIDTH_DEF + 1) + 1,
   parameter int EW = 2 * MW + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 clr,
   input  wire logic                 neg,
   input  wire logic signed [MW-1:0] opnd_a,
   input  wire logic signed [MW-1:0] opnd_b,
   output logic                      done,
   output logic signed [EW-1:0]      acc
);

   localparam int DB   = DIGIT_BITS;
   localparam int NDIG = (MW + DB - 1) / DB;
   localparam int BW   = NDIG * DB;
   localparam int CNTW = $clog2(NDIG + 1);
   localparam int PW   = MW + DB + 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic signed [MW-1:0] a_ff, a_in;
   logic [BW-1:0]        b_ff, b_in;
   logic signed [EW-1:0] t_ff, t_in;
   logic signed [EW-1:0] acc_ff, acc_in;
   logic                 clr_ff, clr_in;
   logic                 neg_ff, neg_in;

   logic [DB-1:0]        top_dig;
   logic signed [DB:0]   dig;
   logic signed [PW-1:0] prod;
   logic signed [EW-1:0] prod_x;
   logic signed [EW-1:0] base;

   // current digit: the first one carries the sign of b
   assign top_dig = b_ff[BW-1 -: DB];
   assign dig     = (cnt_ff == '0) ? $signed({top_dig[DB-1], top_dig})
                                   : $signed({1'b0, top_dig});
   assign prod    = a_ff * dig;
   assign prod_x  = {{(EW - PW){prod[PW-1]}}, prod};
   assign base    = clr_ff ? '0 : acc_ff;

   // advance one digit per cycle, then fold the term into the accumulator
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      t_in    = t_ff;
      acc_in  = acc_ff;
      clr_in  = clr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = opnd_a;
         b_in    = BW'(opnd_b);
         t_in    = '0;
         clr_in  = clr;
         neg_in  = neg;
      end else if (busy_ff) begin
         if (cnt_ff == CNTW'(NDIG)) begin
            acc_in  = neg_ff ? (base - t_ff) : (base + t_ff);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            t_in   = {t_ff[EW-DB-1:0], {DB{1'b0}}} + prod_x;
            b_in   = {b_ff[BW-DB-1:0], {DB{1'b0}}};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
      clr_ff <= clr_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule : stnh_mac

`default_nettype wire

>>> sv/stnh_div.sv
// Restoring fraction divider: quot = floor(num * 2^FRAC_Q / den), num < den.
// One quotient bit per cycle.
// Depends on stnh_pkg.
`default_nettype none

module stnh_div
   import stnh_pkg::*;
#(
   parameter int SW = 3 * (COORD_WIDTH_DEF + 1) + 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SW-1:0]     num,
   input  wire logic [SW:0]       den,
   output logic                   done,
   output logic [FRAC_Q-1:0]      quot
);

   localparam int CNTW = $clog2(FRAC_Q + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [SW:0]       rem_ff, rem_in;
   logic [SW:0]       den_ff, den_in;
   logic [FRAC_Q-1:0] q_ff, q_in;

   logic [SW+1:0]     shifted;
   logic [SW+1:0]     diff;
   logic              fits;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   // shift, compare, subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SW:0] : shifted[SW:0];
         q_in   = {q_ff[FRAC_Q-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(FRAC_Q - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule : stnh_div

`default_nettype wire
